// ----- rtl/core/pcpfl_pkg.sv -----
package pcpfl_pkg;

    localparam int AW = 34;

    localparam int CPU_COUNT_DEF  = 8;
    localparam int PAGE_SLOTS_DEF = 32768;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam logic [AW-1:0] RANGE_START_RST = 34'h080000000;
    localparam logic [AW-1:0] RANGE_END_RST   = 34'h088000000;

    localparam logic CFG_RANGE_START = 1'b0;
    localparam logic CFG_RANGE_END   = 1'b1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    typedef enum logic [1:0] {
        KIND_ALLOC,
        KIND_FREE,
        KIND_BAD
    } t_kind;

    typedef enum logic {
        BK_READY,
        BK_POP
    } t_back_state;

endpackage

// ----- rtl/core/per_cpu_page_free_list_top.sv -----
// Per-CPU page free-list allocator with stealing.
// Request channel: an item is taken on a clock edge with start high and
// busy low. i_mode selects alloc or free, i_cpu the requesting CPU,
// i_page_address the page returned on a free.
// Result channel: o_done is high for one cycle per item, in item order,
// with o_granted_address and o_status. The receiver cannot stall it.
// Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index (0 range_start,
// 1 range_end) and i_cfg_data; ready is always high. Write only when idle.
// A free, a refused free or an alloc with nothing free has its result
// registered as the engine takes it; a successful alloc first waits in
// BK_POP for the link memory read. Throughput: the stack engine takes
// one item per cycle for frees; an alloc that finds a page holds it in
// BK_POP until the registered link read gives the new head. A 2-entry
// queue between the classifier and the stack engine absorbs bursts;
// busy is queue full. Reset empties all per-CPU stacks and loads the
// range registers; the link memory is not cleared and needs no sweep.
module per_cpu_page_free_list_top
    import pcpfl_pkg::*;
#(
    parameter int CPU_COUNT  = CPU_COUNT_DEF,
    parameter int PAGE_SLOTS = PAGE_SLOTS_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic          i_mode,
    input  logic [2:0]    i_cpu,
    input  logic [AW-1:0] i_page_address,
    output logic          o_done,
    output logic [AW-1:0] o_granted_address,
    output logic [1:0]    o_status,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_index,
    input  logic [AW-1:0] i_cfg_data
);

    localparam int CW   = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int IW   = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
    localparam int SW   = $clog2(PAGE_SLOTS + 1);
    localparam int PNW  = AW - PAGE_SHIFT;
    localparam int BW   = PNW + 1;
    localparam int SUMW = ((AW > SW + PAGE_SHIFT) ? AW : SW + PAGE_SHIFT) + 2;
    localparam int LW   = SUMW - PAGE_SHIFT;
    localparam int QW   = 2 + CW + IW;

    localparam logic [SUMW-1:0] ROUND_UP = SUMW'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [SUMW-1:0] CAP_ADD  =
        ROUND_UP + SUMW'(64'(PAGE_SLOTS) << PAGE_SHIFT);
    localparam logic [SUMW-1:0] BASE_RST_SUM = SUMW'(RANGE_START_RST) + ROUND_UP;
    localparam logic [SUMW-1:0] LIM_RST_SUM  = SUMW'(RANGE_START_RST) + CAP_ADD;

    logic [AW-1:0]   r_range_start;
    logic [AW-1:0]   r_range_end;
    logic [BW-1:0]   r_base;
    logic [LW-1:0]   r_limit;
    logic [SUMW-1:0] base_sum;
    logic [SUMW-1:0] lim_sum;
    logic            cfg_we;

    t_kind           f_kind;
    logic [CW-1:0]   f_cpu;
    logic [IW-1:0]   f_slot;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    logic [QW-1:0]   q_data;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign base_sum    = SUMW'(i_cfg_data) + ROUND_UP;
    assign lim_sum     = SUMW'(i_cfg_data) + CAP_ADD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_start <= RANGE_START_RST;
            r_range_end   <= RANGE_END_RST;
            r_base        <= BASE_RST_SUM[PAGE_SHIFT +: BW];
            r_limit       <= LIM_RST_SUM[PAGE_SHIFT +: LW];
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_RANGE_START: begin
                    r_range_start <= i_cfg_data;
                    r_base        <= base_sum[PAGE_SHIFT +: BW];
                    r_limit       <= lim_sum[PAGE_SHIFT +: LW];
                end
                CFG_RANGE_END: begin
                    r_range_end <= i_cfg_data;
                end
                default: begin
                    r_range_end <= r_range_end;
                end
            endcase
        end
    end

    assign busy = q_full;

    pcpfl_front #(
        .CPU_COUNT  (CPU_COUNT),
        .PAGE_SLOTS (PAGE_SLOTS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_front (
        .i_mode         (i_mode),
        .i_cpu          (i_cpu),
        .i_page_address (i_page_address),
        .i_range_start  (r_range_start),
        .i_range_end    (r_range_end),
        .i_base         (r_base),
        .i_limit        (r_limit),
        .o_kind         (f_kind),
        .o_cpu          (f_cpu),
        .o_slot         (f_slot)
    );

    pcpfl_queue #(
        .DW (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start),
        .i_data  ({f_kind, f_cpu, f_slot}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    pcpfl_back #(
        .CPU_COUNT  (CPU_COUNT),
        .PAGE_SLOTS (PAGE_SLOTS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (q_empty),
        .i_cmd             (q_data),
        .o_pop             (q_pop),
        .i_base            (r_base),
        .o_done            (o_done),
        .o_granted_address (o_granted_address),
        .o_status          (o_status)
    );

endmodule

// ----- rtl/core/pcpfl_front.sv -----
module pcpfl_front
    import pcpfl_pkg::*;
#(
    parameter int CPU_COUNT  = CPU_COUNT_DEF,
    parameter int PAGE_SLOTS = PAGE_SLOTS_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
    localparam int CW   = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1,
    localparam int IW   = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1,
    localparam int SW   = $clog2(PAGE_SLOTS + 1),
    localparam int PNW  = AW - PAGE_SHIFT,
    localparam int BW   = PNW + 1,
    localparam int SUMW = ((AW > SW + PAGE_SHIFT) ? AW : SW + PAGE_SHIFT) + 2,
    localparam int LW   = SUMW - PAGE_SHIFT
) (
    input  logic          i_mode,
    input  logic [2:0]    i_cpu,
    input  logic [AW-1:0] i_page_address,
    input  logic [AW-1:0] i_range_start,
    input  logic [AW-1:0] i_range_end,
    input  logic [BW-1:0] i_base,
    input  logic [LW-1:0] i_limit,
    output t_kind         o_kind,
    output logic [CW-1:0] o_cpu,
    output logic [IW-1:0] o_slot
);

    localparam int SUBW = (BW > IW) ? BW : IW;

    logic [2:0]      cpu_mod;
    logic [PNW-1:0]  page_num;
    logic [SUBW-1:0] diff;
    logic            free_ok;

    always_comb begin
        cpu_mod = i_cpu;
        for (int k = 0; k < 7; k++) begin
            if (int'(cpu_mod) >= CPU_COUNT) begin
                cpu_mod = cpu_mod - 3'(CPU_COUNT);
            end
        end
    end

    assign page_num = i_page_address[AW-1:PAGE_SHIFT];
    assign diff     = SUBW'(page_num) - SUBW'(i_base);

    // aligned, inside [start, end) and below slot capacity
    assign free_ok = (i_page_address[PAGE_SHIFT-1:0] == '0)
                   && (i_page_address >= i_range_start)
                   && (i_page_address < i_range_end)
                   && (LW'(page_num) < i_limit);

    always_comb begin
        if (i_mode == MODE_FREE) begin
            o_kind = free_ok ? KIND_FREE : KIND_BAD;
        end else begin
            o_kind = KIND_ALLOC;
        end
    end

    assign o_cpu  = CW'(cpu_mod);
    assign o_slot = diff[IW-1:0];

endmodule

// ----- rtl/core/pcpfl_queue.sv -----
module pcpfl_queue
    import pcpfl_pkg::*;
#(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_empty
);

    logic [DW-1:0] r_mem [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_count;
    logic          n_wptr;
    logic          n_rptr;
    logic [1:0]    n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = do_push ? !r_wptr : r_wptr;
        n_rptr  = do_pop ? !r_rptr : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/pcpfl_back.sv -----
module pcpfl_back
    import pcpfl_pkg::*;
#(
    parameter int CPU_COUNT  = CPU_COUNT_DEF,
    parameter int PAGE_SLOTS = PAGE_SLOTS_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
    localparam int CW  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1,
    localparam int IW  = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1,
    localparam int PNW = AW - PAGE_SHIFT,
    localparam int BW  = PNW + 1,
    localparam int QW  = 2 + CW + IW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  logic [QW-1:0] i_cmd,
    output logic          o_pop,
    input  logic [BW-1:0] i_base,
    output logic          o_done,
    output logic [AW-1:0] o_granted_address,
    output logic [1:0]    o_status
);

    localparam int SW = $clog2(PAGE_SLOTS + 1);
    localparam int GW = ((BW > SW) ? BW : SW) + 1;
    localparam logic [SW-1:0] NULL_SLOT = SW'(PAGE_SLOTS);

    t_back_state    r_state;
    t_back_state    n_state;
    logic [SW-1:0]  r_head [CPU_COUNT];
    logic [SW-1:0]  n_head [CPU_COUNT];
    logic [CW-1:0]  r_vic;
    logic [CW-1:0]  n_vic;
    logic [SW-1:0]  r_slot;
    logic [SW-1:0]  n_slot;
    logic           r_res_valid;
    logic           n_res_valid;
    logic [AW-1:0]  r_res_addr;
    logic [AW-1:0]  n_res_addr;
    logic [1:0]     r_res_status;
    logic [1:0]     n_res_status;

    logic [SW-1:0]  r_links [PAGE_SLOTS];
    logic [SW-1:0]  r_link_q;
    logic           mem_we;
    logic           mem_re;
    logic [IW-1:0]  mem_waddr;
    logic [IW-1:0]  mem_raddr;
    logic [SW-1:0]  mem_wdata;

    t_kind          cmd_kind;
    logic [CW-1:0]  cmd_cpu;
    logic [IW-1:0]  cmd_slot;
    logic [CPU_COUNT-1:0] nonempty;
    logic           found;
    logic [CW-1:0]  vic;
    logic [CW-1:0]  sel_idx;
    logic [SW-1:0]  head_sel;
    logic [GW-1:0]  gsum;

    assign cmd_kind = t_kind'(i_cmd[QW-1 -: 2]);
    assign cmd_cpu  = i_cmd[IW +: CW];
    assign cmd_slot = i_cmd[IW-1:0];

    always_comb begin
        for (int i = 0; i < CPU_COUNT; i++) begin
            nonempty[i] = (r_head[i] < NULL_SLOT);
        end
    end

    // own stack first, else lowest-numbered other non-empty stack
    always_comb begin
        found = 1'b0;
        vic   = cmd_cpu;
        if (nonempty[cmd_cpu]) begin
            found = 1'b1;
        end else begin
            for (int i = CPU_COUNT - 1; i >= 0; i--) begin
                if (nonempty[i] && (CW'(i) != cmd_cpu)) begin
                    found = 1'b1;
                    vic   = CW'(i);
                end
            end
        end
    end

    assign sel_idx  = (cmd_kind == KIND_FREE) ? cmd_cpu : vic;
    assign head_sel = r_head[sel_idx];
    assign gsum     = GW'(i_base) + GW'(r_slot);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_vic        = r_vic;
        n_slot       = r_slot;
        n_res_valid  = 1'b0;
        n_res_addr   = '0;
        n_res_status = ST_OK;
        o_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = cmd_slot;
        mem_wdata    = head_sel;
        mem_raddr    = head_sel[IW-1:0];
        case (r_state)
            BK_READY: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (cmd_kind)
                        KIND_FREE: begin
                            mem_we           = 1'b1;
                            n_head[cmd_cpu]  = SW'(cmd_slot);
                            n_res_valid      = 1'b1;
                        end
                        KIND_ALLOC: begin
                            if (found) begin
                                mem_re  = 1'b1;
                                n_vic   = vic;
                                n_slot  = head_sel;
                                n_state = BK_POP;
                            end else begin
                                n_res_valid  = 1'b1;
                                n_res_status = ST_EMPTY;
                            end
                        end
                        default: begin
                            n_res_valid  = 1'b1;
                            n_res_status = ST_BAD;
                        end
                    endcase
                end
            end
            BK_POP: begin
                n_head[r_vic] = r_link_q;
                n_res_valid   = 1'b1;
                n_res_addr    = {gsum[PNW-1:0], {PAGE_SHIFT{1'b0}}};
                n_state       = BK_READY;
            end
            default: begin
                n_state = BK_READY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_READY;
            r_res_valid <= 1'b0;
            for (int i = 0; i < CPU_COUNT; i++) begin
                r_head[i] <= NULL_SLOT;
            end
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            r_head      <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vic        <= n_vic;
        r_slot       <= n_slot;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_links[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_link_q <= r_links[mem_raddr];
        end
    end

    assign o_done            = r_res_valid;
    assign o_granted_address = r_res_addr;
    assign o_status          = r_res_status;

    a_pop_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_POP) |=> (r_state == BK_READY) && r_res_valid)
        else $error("pop did not finish in one cycle");

    a_no_take_in_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_POP) |-> !o_pop)
        else $error("item taken while link read pending");

    a_popped_slot_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_POP) |-> (r_slot < NULL_SLOT))
        else $error("popped slot is the empty marker");

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> $past(o_pop) || $past(r_state == BK_POP))
        else $error("result without a command");

endmodule

// ----- tb/tb_per_cpu_page_free_list_top.sv -----
module tb_per_cpu_page_free_list_top
    import pcpfl_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          STALL_LIMIT = 2000;
    localparam logic [15:0] NULL_SLOT   = 16'(PAGE_SLOTS_DEF);
    localparam logic [63:0] PAGE_MASK   = (64'd1 << PAGE_SHIFT_DEF) - 64'd1;

    typedef struct packed {
        logic [AW-1:0] addr;
        logic [1:0]    status;
    } t_page_result;

    typedef struct packed {
        logic          mode;
        logic [2:0]    cpu;
        logic [AW-1:0] addr;
        logic          typed;
        logic [AW-1:0] want_addr;
        logic [1:0]    want_status;
    } t_page_op_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic          i_mode;
    logic [2:0]    i_cpu;
    logic [AW-1:0] i_page_address;
    logic          o_done;
    logic [AW-1:0] o_granted_address;
    logic [1:0]    o_status;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic          i_cfg_index;
    logic [AW-1:0] i_cfg_data;

    // mirror of the allocator
    logic [AW-1:0] cfg_start;
    logic [AW-1:0] cfg_end;
    logic [15:0]   free_heads [CPU_COUNT_DEF];
    logic [15:0]   free_links [PAGE_SLOTS_DEF];
    bit            slot_held  [PAGE_SLOTS_DEF];

    t_page_result  page_results[$];
    t_page_op_row  dir_rows[24];
    int            fail_count = 0;
    int            stall_cycles = 0;

    per_cpu_page_free_list_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_mode            (i_mode),
        .i_cpu             (i_cpu),
        .i_page_address    (i_page_address),
        .o_done            (o_done),
        .o_granted_address (o_granted_address),
        .o_status          (o_status),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [63:0] base_page();
        return ({30'd0, cfg_start} + PAGE_MASK) >> PAGE_SHIFT_DEF;
    endfunction

    function automatic t_page_result predict_page_op(input logic m, input logic [2:0] c,
                                                     input logic [AW-1:0] a);
        t_page_result r;
        logic [63:0]  bp;
        logic [63:0]  slot;
        logic [63:0]  grant;
        logic [15:0]  s;
        int           victim;
        r = '0;
        bp = base_page();
        if (m == MODE_FREE) begin
            slot = ({30'd0, a} >> PAGE_SHIFT_DEF) - bp;
            if ((({30'd0, a} & PAGE_MASK) != 0) || a < cfg_start || a >= cfg_end ||
                slot >= PAGE_SLOTS_DEF) begin
                r.status = ST_BAD;
            end else begin
                free_links[slot] = free_heads[c];
                free_heads[c] = slot[15:0];
                slot_held[slot] = 1'b1;
                r.status = ST_OK;
            end
        end else begin
            victim = -1;
            if (free_heads[c] != NULL_SLOT) begin
                victim = c;
            end else begin
                for (int i = 0; i < CPU_COUNT_DEF; i++) begin
                    if (victim < 0 && i != c && free_heads[i] != NULL_SLOT) victim = i;
                end
            end
            if (victim < 0) begin
                r.status = ST_EMPTY;
            end else begin
                s = free_heads[victim];
                free_heads[victim] = free_links[s];
                slot_held[s] = 1'b0;
                grant = (bp + 64'(s)) << PAGE_SHIFT_DEF;
                r.addr = grant[AW-1:0];
                r.status = ST_OK;
            end
        end
        return r;
    endfunction

    task automatic issue_page_op(input logic m, input logic [2:0] c, input logic [AW-1:0] a,
                                 input logic typed, input t_page_result want);
        t_page_result predicted;
        @(negedge i_clk);
        start <= 1'b1;
        i_mode <= m;
        i_cpu <= c;
        i_page_address <= a;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = predict_page_op(m, c, a);
        page_results.push_back(typed ? want : predicted);
    endtask

    task automatic pause_items(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic write_range(input logic idx, input logic [AW-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_RANGE_START) cfg_start = val;
        else cfg_end = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        pause_items(1);
        while (page_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_range(input logic [AW-1:0] lo, input logic [AW-1:0] hi);
        drain_results();
        write_range(CFG_RANGE_START, lo);
        write_range(CFG_RANGE_END, hi);
    endtask

    task automatic run_random(input int n);
        int            alloc_pct;
        int            r;
        bit            quiet;
        bit            found;
        logic [63:0]   s;
        logic [63:0]   a64;
        logic [AW-1:0] a;
        alloc_pct = 50;
        quiet = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                r = $urandom_range(0, 2);
                alloc_pct = (r == 0) ? 25 : (r == 1) ? 50 : 75;
                quiet = ($urandom_range(0, 4) == 0);
            end
            r = $urandom_range(0, 99);
            a = {$urandom, $urandom};
            if (r < alloc_pct) begin
                issue_page_op(MODE_ALLOC, 3'($urandom), a, 1'b0, '0);
            end else if (r < alloc_pct + 12) begin
                // noise: arbitrary or misaligned addresses
                if ($urandom_range(0, 1)) begin
                    a64 = (base_page() + 64'($urandom_range(0, 255))) << PAGE_SHIFT_DEF;
                    a = a64[AW-1:0] | AW'($urandom_range(1, 4095));
                end
                issue_page_op(MODE_FREE, 3'($urandom), a, 1'b0, '0);
            end else begin
                found = 1'b0;
                s = 0;
                for (int k = 0; k < 8 && !found; k++) begin
                    if ($urandom_range(0, 19) == 0)
                        s = PAGE_SLOTS_DEF + $urandom_range(0, 64);
                    else if ($urandom_range(0, 1))
                        s = $urandom_range(0, PAGE_SLOTS_DEF - 1);
                    else
                        s = $urandom_range(0, 127);
                    found = (s >= PAGE_SLOTS_DEF) || !slot_held[s];
                end
                if (found) begin
                    a64 = (base_page() + s) << PAGE_SHIFT_DEF;
                    issue_page_op(MODE_FREE, 3'($urandom), a64[AW-1:0], 1'b0, '0);
                end else begin
                    issue_page_op(MODE_ALLOC, 3'($urandom), a, 1'b0, '0);
                end
            end
            pause_items(pick_gap(quiet));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (page_results.size() == 0) begin
                $display("%0t: result with none expected: granted_address %h status %0d",
                         $time, o_granted_address, o_status);
                fail_count++;
            end else begin
                if (o_granted_address !== page_results[0].addr) begin
                    $display("%0t: granted_address expected %h actual %h",
                             $time, page_results[0].addr, o_granted_address);
                    fail_count++;
                end
                if (o_status !== page_results[0].status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, page_results[0].status, o_status);
                    fail_count++;
                end
                void'(page_results.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("per_cpu_page_free_list_top verification failed");
        $finish;
    end

    initial begin
        t_page_result want;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_mode = MODE_ALLOC;
        i_cpu = '0;
        i_page_address = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_RANGE_START;
        i_cfg_data = '0;
        cfg_start = RANGE_START_RST;
        cfg_end = RANGE_END_RST;
        for (int i = 0; i < CPU_COUNT_DEF; i++) free_heads[i] = NULL_SLOT;
        for (int i = 0; i < PAGE_SLOTS_DEF; i++) slot_held[i] = 1'b0;

        dir_rows = '{
            '{MODE_ALLOC, 3'd0, 34'h000000000, 1'b1, 34'h000000000, ST_EMPTY},
            '{MODE_FREE,  3'd0, 34'h080000001, 1'b1, 34'h000000000, ST_BAD},
            '{MODE_FREE,  3'd1, 34'h07FFFF000, 1'b1, 34'h000000000, ST_BAD},
            '{MODE_FREE,  3'd2, 34'h088000000, 1'b1, 34'h000000000, ST_BAD},
            '{MODE_FREE,  3'd3, 34'h000000000, 1'b1, 34'h000000000, ST_BAD},
            '{MODE_FREE,  3'd7, 34'h3FFFFF000, 1'b1, 34'h000000000, ST_BAD},
            '{MODE_FREE,  3'd0, 34'h080000000, 1'b1, 34'h000000000, ST_OK},
            '{MODE_FREE,  3'd0, 34'h080001000, 1'b1, 34'h000000000, ST_OK},
            '{MODE_ALLOC, 3'd0, 34'h000000000, 1'b1, 34'h080001000, ST_OK},
            '{MODE_ALLOC, 3'd5, 34'h000000000, 1'b1, 34'h080000000, ST_OK},
            '{MODE_ALLOC, 3'd7, 34'h000000000, 1'b1, 34'h000000000, ST_EMPTY},
            '{MODE_FREE,  3'd7, 34'h087FFF000, 1'b1, 34'h000000000, ST_OK},
            '{MODE_FREE,  3'd3, 34'h080002000, 1'b1, 34'h000000000, ST_OK},
            '{MODE_ALLOC, 3'd1, 34'h000000000, 1'b1, 34'h080002000, ST_OK},
            '{MODE_ALLOC, 3'd6, 34'h000000000, 1'b1, 34'h087FFF000, ST_OK},
            // double free on two cpus
            '{MODE_FREE,  3'd2, 34'h080003000, 1'b1, 34'h000000000, ST_OK},
            '{MODE_FREE,  3'd4, 34'h080003000, 1'b1, 34'h000000000, ST_OK},
            '{MODE_ALLOC, 3'd4, 34'h3FFFFFFFF, 1'b1, 34'h080003000, ST_OK},
            '{MODE_ALLOC, 3'd2, 34'h000000000, 1'b1, 34'h080003000, ST_OK},
            '{MODE_ALLOC, 3'd2, 34'h000000000, 1'b1, 34'h000000000, ST_EMPTY},
            '{MODE_FREE,  3'd6, 34'h080004000, 1'b0, 34'h000000000, ST_OK},
            '{MODE_FREE,  3'd6, 34'h080005000, 1'b0, 34'h000000000, ST_OK},
            '{MODE_ALLOC, 3'd6, 34'h000000000, 1'b0, 34'h000000000, ST_OK},
            '{MODE_ALLOC, 3'd0, 34'h000000000, 1'b0, 34'h000000000, ST_OK}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            want.addr = dir_rows[i].want_addr;
            want.status = dir_rows[i].want_status;
            issue_page_op(dir_rows[i].mode, dir_rows[i].cpu, dir_rows[i].addr,
                          dir_rows[i].typed, want);
            pause_items(pick_gap(1'b0));
        end

        run_random(150);
        set_range(34'h000000000, 34'h3FFFFFFFF);
        run_random(150);
        // misaligned start, narrow window
        set_range(34'h123456789, 34'h127456789);
        run_random(150);
        // top of the address space, grants do not wrap
        set_range(34'h3FFFF8000, 34'h3FFFFFFFF);
        run_random(150);
        set_range(34'h3FFFFFFFF, 34'h000000000);
        run_random(120);
        set_range(RANGE_START_RST, RANGE_END_RST);
        run_random(150);

        drain_results();
        if (fail_count == 0)
            $display("per_cpu_page_free_list_top verification clean");
        else
            $display("per_cpu_page_free_list_top verification failed");
        $finish;
    end

endmodule
